[sv/gps_fix_delta_encoder_macros.svh]
// assertion macros shared by the gps fix delta encoder rtl
// depends on nothing; included by files that carry concurrent checks
`ifndef GPS_FIX_DELTA_ENCODER_MACROS_SVH
`define GPS_FIX_DELTA_ENCODER_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define GFDE_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define GFDE_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/gfde_pkg.sv]
// constants and types for the gps fix delta encoder
// depends on nothing
`default_nettype none

package gfde_pkg;

    localparam int LAT_W   = 28;
    localparam int LON_W   = 29;
    localparam int TIME_W  = 31;
    localparam int SPEED_W = 7;
    localparam int MODE_W  = 2;
    localparam int COUNT_W = 8;

    localparam int DLAT_W  = 15;
    localparam int DLON_W  = 15;
    localparam int DTIME_W = 13;
    localparam int TLOW_W  = 4;

    localparam int DELTA_COORD_MAX = 16383;
    localparam int DELTA_TIME_MAX  = 8191;

    localparam logic [SPEED_W-1:0] SPEED_MISSING   = 7'd127;
    localparam logic [COUNT_W-1:0] MAX_COUNT_RESET = 8'd10;

    typedef enum logic {
        KIND_FULL  = 1'b0,
        KIND_DELTA = 1'b1
    } record_kind_t;

endpackage

`default_nettype wire

[sv/gps_fix_delta_encoder.sv]
// gps fix delta encoder: an input register, one pass of subtract, compare and
// select logic, and a result register. depends on gfde_pkg and the macro header.
// item path: input register, result register; one item per cycle unless m_ready stalls.
// the delta count, and on a full item the base fix, are updated as an item passes
// to the result register, so the following item sees the new base with no bubble.
// reset (synchronous, aresetn low): both stages empty, no base fix, count 0, limit 10.
`default_nettype none
`include "gps_fix_delta_encoder_macros.svh"

module gps_fix_delta_encoder (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,

    input  wire logic                                  cfg_we,
    input  wire logic [gfde_pkg::COUNT_W-1:0]          cfg_wdata,

    input  wire logic                                  s_valid,
    output logic                                       s_ready,
    input  wire logic signed [gfde_pkg::LAT_W-1:0]     s_latitude_udeg,
    input  wire logic signed [gfde_pkg::LON_W-1:0]     s_longitude_udeg,
    input  wire logic [gfde_pkg::TIME_W-1:0]           s_fix_time,
    input  wire logic [gfde_pkg::SPEED_W-1:0]          s_speed_value,
    input  wire logic                                  s_speed_valid,
    input  wire logic                                  s_provider_id,
    input  wire logic [gfde_pkg::MODE_W-1:0]           s_fix_mode,
    input  wire logic                                  s_fix_present,

    output logic                                       m_valid,
    input  wire logic                                  m_ready,
    output logic                                       m_record_kind,
    output logic                                       m_full_provider,
    output logic signed [gfde_pkg::LAT_W-1:0]          m_full_latitude,
    output logic signed [gfde_pkg::LON_W-1:0]          m_full_longitude,
    output logic [gfde_pkg::TIME_W-1:0]                m_full_time,
    output logic [gfde_pkg::TLOW_W-1:0]                m_base_time_low,
    output logic signed [gfde_pkg::DLAT_W-1:0]         m_delta_latitude,
    output logic signed [gfde_pkg::DLON_W-1:0]         m_delta_longitude,
    output logic [gfde_pkg::DTIME_W-1:0]               m_delta_time,
    output logic [gfde_pkg::SPEED_W-1:0]               m_speed_code,
    output logic [gfde_pkg::MODE_W-1:0]                m_mode_out
);

    import gfde_pkg::*;

    // configuration
    logic [COUNT_W-1:0]       max_count_reg;

    // input stage
    logic                     in_valid_reg;
    logic signed [LAT_W-1:0]  in_lat_reg;
    logic signed [LON_W-1:0]  in_lon_reg;
    logic [TIME_W-1:0]        in_time_reg;
    logic [SPEED_W-1:0]       in_speed_reg;
    logic                     in_speed_ok_reg;
    logic                     in_prov_reg;
    logic [MODE_W-1:0]        in_mode_reg;
    logic                     in_present_reg;

    // base fix
    logic                     base_valid_reg;
    logic signed [LAT_W-1:0]  base_lat_reg;
    logic signed [LON_W-1:0]  base_lon_reg;
    logic [TIME_W-1:0]        base_time_reg;
    logic [COUNT_W-1:0]       delta_count_reg;

    // result stage
    logic                     out_valid_reg;
    record_kind_t             out_kind_reg;
    logic                     out_prov_reg;
    logic signed [LAT_W-1:0]  out_lat_reg;
    logic signed [LON_W-1:0]  out_lon_reg;
    logic [TIME_W-1:0]        out_time_reg;
    logic [TLOW_W-1:0]        out_tlow_reg;
    logic signed [DLAT_W-1:0] out_dlat_reg;
    logic signed [DLON_W-1:0] out_dlon_reg;
    logic [DTIME_W-1:0]       out_dtime_reg;
    logic [SPEED_W-1:0]       out_speed_reg;
    logic [MODE_W-1:0]        out_mode_reg;

    logic                     out_free;
    logic                     advance;
    logic                     s_take;

    logic signed [LAT_W:0]    lat_diff;
    logic signed [LON_W:0]    lon_diff;
    logic signed [TIME_W:0]   time_diff;
    logic                     lat_ok;
    logic                     lon_ok;
    logic                     time_ok;
    record_kind_t             kind_next;
    logic [COUNT_W-1:0]       delta_count_next;

    assign out_free = !out_valid_reg || m_ready;
    assign advance  = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || advance;
    assign s_take   = s_valid && s_ready;

    assign lat_diff  = $signed({in_lat_reg[LAT_W-1], in_lat_reg})
                     - $signed({base_lat_reg[LAT_W-1], base_lat_reg});
    assign lon_diff  = $signed({in_lon_reg[LON_W-1], in_lon_reg})
                     - $signed({base_lon_reg[LON_W-1], base_lon_reg});
    assign time_diff = $signed({1'b0, in_time_reg}) - $signed({1'b0, base_time_reg});

    assign lat_ok  = (lat_diff >= -DELTA_COORD_MAX) && (lat_diff <= DELTA_COORD_MAX);
    assign lon_ok  = (lon_diff >= -DELTA_COORD_MAX) && (lon_diff <= DELTA_COORD_MAX);
    assign time_ok = !time_diff[TIME_W] && (time_diff <= DELTA_TIME_MAX);

    always_comb begin
        if (base_valid_reg && (delta_count_reg < max_count_reg) && lat_ok && lon_ok
                && time_ok) begin
            kind_next        = KIND_DELTA;
            delta_count_next = delta_count_reg + COUNT_W'(1);
        end else begin
            kind_next        = KIND_FULL;
            delta_count_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_count_reg <= MAX_COUNT_RESET;
        end else if (cfg_we) begin
            max_count_reg <= cfg_wdata;
        end
    end

    // input stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_lat_reg      <= s_latitude_udeg;
            in_lon_reg      <= s_longitude_udeg;
            in_time_reg     <= s_fix_time;
            in_speed_reg    <= s_speed_value;
            in_speed_ok_reg <= s_speed_valid;
            in_prov_reg     <= s_provider_id;
            in_mode_reg     <= s_fix_mode;
            in_present_reg  <= s_fix_present;
        end
    end

    // base fix and count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_valid_reg  <= 1'b0;
            delta_count_reg <= '0;
        end else if (advance) begin
            delta_count_reg <= delta_count_next;
            if (kind_next == KIND_FULL) begin
                base_valid_reg <= in_present_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && (kind_next == KIND_FULL)) begin
            base_lat_reg  <= in_lat_reg;
            base_lon_reg  <= in_lon_reg;
            base_time_reg <= in_time_reg;
        end
    end

    // result stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_kind_reg  <= kind_next;
            out_speed_reg <= in_speed_ok_reg ? in_speed_reg : SPEED_MISSING;
            out_mode_reg  <= in_mode_reg;
            unique case (kind_next)
                KIND_DELTA: begin
                    out_prov_reg  <= 1'b0;
                    out_lat_reg   <= '0;
                    out_lon_reg   <= '0;
                    out_time_reg  <= '0;
                    out_tlow_reg  <= base_time_reg[TLOW_W-1:0];
                    out_dlat_reg  <= lat_diff[DLAT_W-1:0];
                    out_dlon_reg  <= lon_diff[DLON_W-1:0];
                    out_dtime_reg <= time_diff[DTIME_W-1:0];
                end
                KIND_FULL: begin
                    out_prov_reg  <= in_prov_reg;
                    out_lat_reg   <= in_lat_reg;
                    out_lon_reg   <= in_lon_reg;
                    out_time_reg  <= in_time_reg;
                    out_tlow_reg  <= '0;
                    out_dlat_reg  <= '0;
                    out_dlon_reg  <= '0;
                    out_dtime_reg <= '0;
                end
                default: begin
                    out_prov_reg  <= 1'b0;
                    out_lat_reg   <= '0;
                    out_lon_reg   <= '0;
                    out_time_reg  <= '0;
                    out_tlow_reg  <= '0;
                    out_dlat_reg  <= '0;
                    out_dlon_reg  <= '0;
                    out_dtime_reg <= '0;
                end
            endcase
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_record_kind     = out_kind_reg;
    assign m_full_provider   = out_prov_reg;
    assign m_full_latitude   = out_lat_reg;
    assign m_full_longitude  = out_lon_reg;
    assign m_full_time       = out_time_reg;
    assign m_base_time_low   = out_tlow_reg;
    assign m_delta_latitude  = out_dlat_reg;
    assign m_delta_longitude = out_dlon_reg;
    assign m_delta_time      = out_dtime_reg;
    assign m_speed_code      = out_speed_reg;
    assign m_mode_out        = out_mode_reg;

    // checks
    `GFDE_ASSERT_NOW(a_delta_needs_base, aclk, aresetn,
        advance && (kind_next == KIND_DELTA),
        base_valid_reg && (delta_count_reg < max_count_reg),
        "delta item without a valid base or over the limit")
    `GFDE_ASSERT_NEXT(a_full_clears_count, aclk, aresetn,
        advance && (kind_next == KIND_FULL),
        delta_count_reg == '0,
        "count not cleared after a full item")
    `GFDE_ASSERT_NEXT(a_delta_bumps_count, aclk, aresetn,
        advance && (kind_next == KIND_DELTA),
        delta_count_reg == COUNT_W'($past(delta_count_reg) + COUNT_W'(1)),
        "count not incremented after a delta item")
    `GFDE_ASSERT_NOW(a_delta_full_fields_zero, aclk, aresetn,
        out_valid_reg && (out_kind_reg == KIND_DELTA),
        (out_lat_reg == '0) && (out_lon_reg == '0) && (out_time_reg == '0) && !out_prov_reg,
        "full fields set in a delta item")
    `GFDE_ASSERT_NEXT(a_input_stage_held, aclk, aresetn,
        in_valid_reg && !advance,
        in_valid_reg && $stable(in_lat_reg) && $stable(in_time_reg),
        "input stage overwritten while stalled")

endmodule

`default_nettype wire
